[design/frequency_admission_filter_assert.svh]
// ----------------------------------------------------------------------------
// frequency_admission_filter_assert.svh
// Assertion macros for the frequency admission filter.
// ----------------------------------------------------------------------------
`ifndef FREQUENCY_ADMISSION_FILTER_ASSERT_SVH
`define FREQUENCY_ADMISSION_FILTER_ASSERT_SVH
`ifndef ASSERT_OFF
`define FAF_ASSERT_ALWAYS(label, clk, rst_n, cond) \
label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("frequency_admission_filter: invariant violated");
`define FAF_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("frequency_admission_filter: implication violated");
`else
`define FAF_ASSERT_ALWAYS(label, clk, rst_n, cond)
`define FAF_ASSERT_IMPLY(label, clk, rst_n, ante, cons)
`endif
`endif

[design/faf_pkg.sv]
// ----------------------------------------------------------------------------
// faf_pkg
// Types, sizes and constants of the frequency admission filter.
// ----------------------------------------------------------------------------
`default_nettype none
package faf_pkg;

    localparam int SKETCH_DEPTH = 1024;
    localparam int FILTER_BITS  = 16384;
    localparam int KEY_WIDTH    = 48;
    localparam int HASH_WAYS    = 4;

    localparam int SK_AW    = $clog2(SKETCH_DEPTH);
    localparam int DK_AW    = $clog2(FILTER_BITS);
    localparam int DK_RAW   = DK_AW - 4;
    localparam int DK_ROWS  = FILTER_BITS / 16;
    localparam int SWP_AW   = (SK_AW > DK_RAW) ? SK_AW : DK_RAW;
    localparam logic [SWP_AW:0] SWP_SK_END = (SWP_AW + 1)'(SKETCH_DEPTH);
    localparam logic [SWP_AW:0] SWP_DK_END = (SWP_AW + 1)'(DK_ROWS);

    localparam int LIMIT_W     = 20;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 20;
    localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_LIMIT     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ADMISSION_ENABLE = 2'd1;
    localparam logic [LIMIT_W-1:0]   SAMPLE_LIMIT_RST     = 20'd15360;

    localparam int QUEUE_DEPTH = 2;

    localparam logic [15:0] NIB_HALF_MASK = 16'h7777;
    localparam logic [3:0]  COUNTER_MAX   = 4'd15;

    localparam logic [63:0] PR1 = 64'h9E3779B185EBCA87;
    localparam logic [63:0] PR2 = 64'hC2B2AE3D27D4EB4F;
    localparam logic [63:0] PR3 = 64'h165667B19E3779F9;
    localparam logic [63:0] PR4 = 64'h85EBCA77C2B2AE63;
    localparam logic [63:0] PR5 = 64'h27D4EB2F165667C5;

    typedef struct packed {
        logic                 opcode;
        logic [KEY_WIDTH-1:0] block_key;
        logic [KEY_WIDTH-1:0] victim_key;
        logic                 victim_present;
        logic                 free_slot;
    } t_in;

    typedef struct packed {
        logic       filter_passed;
        logic       promote_free;
        logic       replace_victim;
        logic [3:0] key_estimate;
        logic [3:0] victim_estimate;
        logic       aged;
    } t_out;

    typedef struct packed {
        logic                 miss;
        logic                 victim_present;
        logic                 free_slot;
        logic [HASH_WAYS-1:0][DK_AW-1:0] dk_idx;
        logic [HASH_WAYS-1:0][SK_AW-1:0] ks_idx;
        logic [HASH_WAYS-1:0][SK_AW-1:0] vs_idx;
    } t_job;

    typedef struct packed {
        logic [LIMIT_W-1:0] sample_limit;
        logic               admission_enable;
    } t_cfg;

endpackage
`default_nettype wire

[design/faf_hash.sv]
// ----------------------------------------------------------------------------
// faf_hash
// Seeded 64-bit hash of one word, one 32x32 partial product per cycle.
// ----------------------------------------------------------------------------
`default_nettype none
module faf_hash (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_start,
    input  wire  [63:0] i_key,
    input  wire  [1:0]  i_seed,
    output logic        o_done,
    output logic [63:0] o_hash
);
    import faf_pkg::*;

    typedef enum logic [1:0] {H_IDLE, H_MUL, H_POST} t_hstate;

    t_hstate     r_state;
    logic [2:0]  r_phase;
    logic [1:0]  r_sub;
    logic [63:0] r_a;
    logic [63:0] r_acc;
    logic [1:0]  r_seed;
    logic [63:0] b_op;
    logic [31:0] mx;
    logic [31:0] my;
    logic [63:0] prod;
    logic [63:0] h_seed;
    logic [63:0] t_mix;
    logic [63:0] t_add;

    always_comb begin
        case (r_phase)
            3'd0:    b_op = PR2;
            3'd1:    b_op = PR1;
            3'd2:    b_op = PR1;
            3'd3:    b_op = PR2;
            default: b_op = PR3;
        endcase
        mx     = (r_sub == 2'd2) ? r_a[63:32] : r_a[31:0];
        my     = (r_sub == 2'd1) ? b_op[63:32] : b_op[31:0];
        prod   = 64'(mx) * 64'(my);
        h_seed = 64'(r_seed) + PR5 + 64'd8;
        t_mix  = h_seed ^ r_acc;
        t_add  = r_acc + PR4;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= H_IDLE;
            r_phase <= 3'd0;
            r_sub   <= 2'd0;
            o_done  <= 1'b0;
        end else begin
            o_done <= 1'b0;
            case (r_state)
                H_IDLE: begin
                    if (i_start) begin
                        r_a     <= i_key;
                        r_seed  <= i_seed;
                        r_phase <= 3'd0;
                        r_sub   <= 2'd0;
                        r_state <= H_MUL;
                    end
                end
                H_MUL: begin
                    if (r_sub == 2'd0) begin
                        r_acc <= prod;
                    end else begin
                        r_acc <= r_acc + {prod[31:0], 32'd0};
                    end
                    if (r_sub == 2'd2) begin
                        r_sub   <= 2'd0;
                        r_state <= H_POST;
                    end else begin
                        r_sub <= r_sub + 2'd1;
                    end
                end
                H_POST: begin
                    r_phase <= r_phase + 3'd1;
                    r_state <= H_MUL;
                    case (r_phase)
                        3'd0:    r_a <= {r_acc[32:0], r_acc[63:33]};
                        3'd1:    r_a <= {t_mix[36:0], t_mix[63:37]};
                        3'd2:    r_a <= t_add ^ (t_add >> 33);
                        3'd3:    r_a <= r_acc ^ (r_acc >> 29);
                        default: begin
                            o_hash  <= r_acc ^ (r_acc >> 32);
                            o_done  <= 1'b1;
                            r_state <= H_IDLE;
                        end
                    endcase
                end
                default: r_state <= H_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

[design/faf_front.sv]
// ----------------------------------------------------------------------------
// faf_front
// Accepts access transactions and computes their table indexes.
// ----------------------------------------------------------------------------
`default_nettype none
module faf_front (
    input  wire           i_clk,
    input  wire           i_rst_n,
    input  wire           i_push,
    output logic          o_full,
    input  faf_pkg::t_in  i_data,
    input  wire           i_hold,
    output logic          o_q_push,
    output faf_pkg::t_job o_job,
    input  wire           i_q_full
);
    import faf_pkg::*;

    typedef enum logic [1:0] {F_IDLE, F_START, F_WAIT, F_PUSH} t_fstate;

    t_fstate     r_state;
    t_in         r_in;
    t_job        r_job;
    logic [2:0]  r_j;
    logic [2:0]  last_j;
    logic        h_done;
    logic [63:0] h_val;
    logic [63:0] h_key;

    assign last_j = (r_in.opcode && r_in.victim_present) ? 3'd7 : 3'd3;
    assign h_key  = r_j[2] ? 64'(r_in.victim_key) : 64'(r_in.block_key);
    assign o_full   = (r_state != F_IDLE) || i_hold;
    assign o_q_push = (r_state == F_PUSH) && !i_q_full;
    assign o_job    = r_job;

    faf_hash u_hash (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_state == F_START),
        .i_key   (h_key),
        .i_seed  (r_j[1:0]),
        .o_done  (h_done),
        .o_hash  (h_val)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= F_IDLE;
            r_j     <= 3'd0;
        end else begin
            case (r_state)
                F_IDLE: begin
                    if (i_push && !o_full) begin
                        r_in                 <= i_data;
                        r_job.miss           <= i_data.opcode;
                        r_job.victim_present <= i_data.victim_present;
                        r_job.free_slot      <= i_data.free_slot;
                        r_j                  <= 3'd0;
                        r_state              <= F_START;
                    end
                end
                F_START: r_state <= F_WAIT;
                F_WAIT: begin
                    if (h_done) begin
                        if (r_j[2]) begin
                            r_job.vs_idx[r_j[1:0]] <= h_val[SK_AW-1:0];
                        end else begin
                            r_job.dk_idx[r_j[1:0]] <= h_val[DK_AW-1:0];
                            r_job.ks_idx[r_j[1:0]] <= h_val[SK_AW-1:0];
                        end
                        if (r_j == last_j) begin
                            r_state <= F_PUSH;
                        end else begin
                            r_j     <= r_j + 3'd1;
                            r_state <= F_START;
                        end
                    end
                end
                F_PUSH: begin
                    if (!i_q_full) begin
                        r_state <= F_IDLE;
                    end
                end
                default: r_state <= F_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

[design/faf_queue.sv]
// ----------------------------------------------------------------------------
// faf_queue
// Short job queue between the front and the back.
// ----------------------------------------------------------------------------
`default_nettype none
module faf_queue (
    input  wire           i_clk,
    input  wire           i_rst_n,
    input  wire           i_push,
    input  faf_pkg::t_job i_job,
    output logic          o_full,
    input  wire           i_pop,
    output faf_pkg::t_job o_job,
    output logic          o_empty
);
    import faf_pkg::*;

    localparam int QAW = $clog2(QUEUE_DEPTH);

    t_job         r_mem [QUEUE_DEPTH];
    logic [QAW-1:0] r_wp;
    logic [QAW-1:0] r_rp;
    logic [QAW:0]   r_cnt;
    logic           do_push;
    logic           do_pop;

    assign o_full  = (r_cnt == (QAW + 1)'(QUEUE_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_job   = r_mem[r_rp];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wp] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (do_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end
endmodule
`default_nettype wire

[design/faf_back.sv]
// ----------------------------------------------------------------------------
// faf_back
// Doorkeeper and sketch updates, aging sweep and admission decision.
// ----------------------------------------------------------------------------
`default_nettype none
module faf_back (
    input  wire           i_clk,
    input  wire           i_rst_n,
    input  faf_pkg::t_cfg i_cfg,
    input  faf_pkg::t_job i_job,
    input  wire           i_q_empty,
    output logic          o_q_pop,
    output logic          o_clearing,
    output logic          o_valid,
    output faf_pkg::t_out o_data,
    input  wire           i_pop
);
    import faf_pkg::*;

    typedef enum logic [3:0] {
        ST_CLR, ST_IDLE, ST_DK_RD, ST_DK_WR, ST_SK_RD, ST_SK_WR, ST_CNT,
        ST_AGE_RD, ST_AGE_WR, ST_DEC, ST_EST_RD, ST_EST_UPD, ST_OUT
    } t_state;

    logic [15:0] r_sk [SKETCH_DEPTH];
    logic [15:0] r_dk [DK_ROWS];

    t_state             r_state;
    t_job               r_job;
    logic [2:0]         r_i;
    logic [SWP_AW-1:0]  r_addr;
    logic [LIMIT_W-1:0] r_cnt;
    logic [15:0]        r_skq;
    logic [15:0]        r_dkq;
    logic               r_all;
    logic               r_promote;
    logic               r_cmp;
    logic               r_aged;
    logic [3:0]         r_ke;
    logic [3:0]         r_ve;

    logic               sk_we;
    logic [SK_AW-1:0]   sk_addr;
    logic [15:0]        sk_wd;
    logic               dk_we;
    logic [DK_RAW-1:0]  dk_addr;
    logic [15:0]        dk_wd;
    logic [3:0]         nib;
    logic [3:0]         nib_inc;
    logic [3:0]         dk_lo;
    logic               in_sk;
    logic               in_dk;
    logic [LIMIT_W-1:0] cnt_next;
    logic               out_free;

    assign nib      = r_skq[{r_i[1:0], 2'b00} +: 4];
    assign nib_inc  = (nib == COUNTER_MAX) ? nib : nib + 4'd1;
    assign dk_lo    = r_job.dk_idx[r_i[1:0]][3:0];
    assign in_sk    = ({1'b0, r_addr} < SWP_SK_END);
    assign in_dk    = ({1'b0, r_addr} < SWP_DK_END);
    assign cnt_next = r_cnt + 1'b1;
    assign out_free = !o_valid || i_pop;
    assign o_q_pop    = (r_state == ST_IDLE) && !i_q_empty;
    assign o_clearing = (r_state == ST_CLR);

    always_comb begin
        sk_we   = 1'b0;
        sk_addr = r_job.ks_idx[r_i[1:0]];
        sk_wd   = r_skq;
        dk_we   = 1'b0;
        dk_addr = r_job.dk_idx[r_i[1:0]][DK_AW-1:4];
        dk_wd   = r_dkq | (16'd1 << dk_lo);
        case (r_state)
            ST_CLR: begin
                sk_addr = r_addr[SK_AW-1:0];
                sk_we   = in_sk;
                sk_wd   = '0;
                dk_addr = r_addr[DK_RAW-1:0];
                dk_we   = in_dk;
                dk_wd   = '0;
            end
            ST_DK_WR: dk_we = 1'b1;
            ST_SK_WR: begin
                sk_we = 1'b1;
                sk_wd[{r_i[1:0], 2'b00} +: 4] = nib_inc;
            end
            ST_AGE_RD: sk_addr = r_addr[SK_AW-1:0];
            ST_AGE_WR: begin
                sk_addr = r_addr[SK_AW-1:0];
                sk_we   = in_sk;
                sk_wd   = (r_skq >> 1) & NIB_HALF_MASK;
                dk_addr = r_addr[DK_RAW-1:0];
                dk_we   = in_dk;
                dk_wd   = '0;
            end
            ST_EST_RD: begin
                sk_addr = r_i[2] ? r_job.vs_idx[r_i[1:0]] : r_job.ks_idx[r_i[1:0]];
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (sk_we) begin
            r_sk[sk_addr] <= sk_wd;
        end
        r_skq <= r_sk[sk_addr];
    end

    always_ff @(posedge i_clk) begin
        if (dk_we) begin
            r_dk[dk_addr] <= dk_wd;
        end
        r_dkq <= r_dk[dk_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLR;
            r_addr  <= '0;
            r_i     <= 3'd0;
            r_cnt   <= '0;
            o_valid <= 1'b0;
        end else begin
            if (i_pop && o_valid && (r_state != ST_OUT)) begin
                o_valid <= 1'b0;
            end
            case (r_state)
                ST_CLR: begin
                    r_addr <= r_addr + 1'b1;
                    if (&r_addr) begin
                        r_state <= ST_IDLE;
                    end
                end
                ST_IDLE: begin
                    if (!i_q_empty) begin
                        r_job     <= i_job;
                        r_i       <= 3'd0;
                        r_all     <= 1'b1;
                        r_promote <= 1'b0;
                        r_cmp     <= 1'b0;
                        r_aged    <= 1'b0;
                        r_ke      <= '0;
                        r_ve      <= '0;
                        r_state   <= i_job.miss ? ST_DK_RD : ST_SK_RD;
                    end
                end
                ST_DK_RD: r_state <= ST_DK_WR;
                ST_DK_WR: begin
                    r_all <= r_all & r_dkq[dk_lo];
                    if (r_i[1:0] == 2'd3) begin
                        r_i     <= 3'd0;
                        r_state <= ST_SK_RD;
                    end else begin
                        r_i     <= r_i + 3'd1;
                        r_state <= ST_DK_RD;
                    end
                end
                ST_SK_RD: r_state <= ST_SK_WR;
                ST_SK_WR: begin
                    if (r_i[1:0] == 2'd3) begin
                        r_state <= ST_CNT;
                    end else begin
                        r_i     <= r_i + 3'd1;
                        r_state <= ST_SK_RD;
                    end
                end
                ST_CNT: begin
                    if (cnt_next >= i_cfg.sample_limit) begin
                        r_cnt   <= '0;
                        r_aged  <= 1'b1;
                        r_addr  <= '0;
                        r_state <= ST_AGE_RD;
                    end else begin
                        r_cnt   <= cnt_next;
                        r_state <= ST_DEC;
                    end
                end
                ST_AGE_RD: r_state <= ST_AGE_WR;
                ST_AGE_WR: begin
                    r_addr  <= r_addr + 1'b1;
                    r_state <= (&r_addr) ? ST_DEC : ST_AGE_RD;
                end
                ST_DEC: begin
                    r_state <= ST_OUT;
                    if (r_job.miss && r_all) begin
                        if (i_cfg.admission_enable && r_job.free_slot) begin
                            r_promote <= 1'b1;
                        end else if (r_job.victim_present) begin
                            r_cmp   <= 1'b1;
                            r_ke    <= COUNTER_MAX;
                            r_ve    <= COUNTER_MAX;
                            r_i     <= 3'd0;
                            r_state <= ST_EST_RD;
                        end
                    end
                end
                ST_EST_RD: r_state <= ST_EST_UPD;
                ST_EST_UPD: begin
                    if (r_i[2]) begin
                        if (nib < r_ve) begin
                            r_ve <= nib;
                        end
                    end else if (nib < r_ke) begin
                        r_ke <= nib;
                    end
                    r_i     <= r_i + 3'd1;
                    r_state <= (r_i == 3'd7) ? ST_OUT : ST_EST_RD;
                end
                ST_OUT: begin
                    if (out_free) begin
                        o_data.filter_passed   <= r_job.miss && r_all;
                        o_data.promote_free    <= r_promote;
                        o_data.replace_victim  <= r_cmp && i_cfg.admission_enable
                                                  && (r_ke > r_ve);
                        o_data.key_estimate    <= r_ke;
                        o_data.victim_estimate <= r_ve;
                        o_data.aged            <= r_aged;
                        o_valid                <= 1'b1;
                        r_state                <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

[design/frequency_admission_filter.sv]
// Steps: the front computes four hashes for a transaction (eight for a miss with a victim),
// then the back end updates the doorkeeper (on a miss) and the sketch tables.
// Back end: table updates, an aging sweep when the sample limit is reached, then estimates.
// The front takes a new transaction only after it has pushed the job of the last one.
// Reset: synchronous active low; a clearing pass follows, with o_full high.
// ----------------------------------------------------------------------------
// frequency_admission_filter
// Frequency-based admission filter: sketch counters with doorkeeper bits.
// ----------------------------------------------------------------------------
`default_nettype none
`include "frequency_admission_filter_assert.svh"
module frequency_admission_filter (
    input  wire                             i_clk,
    input  wire                             i_rst_n,
    input  wire                             i_push,
    output logic                            o_full,
    input  faf_pkg::t_in                    i_data,
    output logic                            o_empty,
    input  wire                             i_pop,
    output faf_pkg::t_out                   o_data,
    input  wire                             i_cfg_valid,
    output logic                            o_cfg_ready,
    input  wire  [faf_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  wire  [faf_pkg::CFG_DATA_W-1:0]  i_cfg_data
);
    import faf_pkg::*;

    t_cfg r_cfg;
    t_job f_job;
    t_job q_job;
    logic f_push;
    logic q_full;
    logic q_empty;
    logic q_pop;
    logic clearing;
    logic b_valid;

    assign o_cfg_ready = 1'b1;
    assign o_empty     = !b_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.sample_limit     <= SAMPLE_LIMIT_RST;
            r_cfg.admission_enable <= 1'b1;
        end else if (i_cfg_valid) begin
            if (i_cfg_index == CFG_SAMPLE_LIMIT) begin
                r_cfg.sample_limit <= i_cfg_data[LIMIT_W-1:0];
            end else if (i_cfg_index == CFG_ADMISSION_ENABLE) begin
                r_cfg.admission_enable <= i_cfg_data[0];
            end
        end
    end

    faf_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (i_push),
        .o_full   (o_full),
        .i_data   (i_data),
        .i_hold   (clearing),
        .o_q_push (f_push),
        .o_job    (f_job),
        .i_q_full (q_full)
    );

    faf_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (f_push),
        .i_job   (f_job),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_job   (q_job),
        .o_empty (q_empty)
    );

    faf_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (r_cfg),
        .i_job      (q_job),
        .i_q_empty  (q_empty),
        .o_q_pop    (q_pop),
        .o_clearing (clearing),
        .o_valid    (b_valid),
        .o_data     (o_data),
        .i_pop      (i_pop)
    );

    `FAF_ASSERT_IMPLY(a_clear_blocks, i_clk, i_rst_n, clearing, o_full)
    `FAF_ASSERT_ALWAYS(a_one_admit, i_clk, i_rst_n, o_empty || !(o_data.promote_free && o_data.replace_victim))
    `FAF_ASSERT_IMPLY(a_replace_cmp, i_clk, i_rst_n, !o_empty && o_data.replace_victim, o_data.key_estimate > o_data.victim_estimate)
    `FAF_ASSERT_IMPLY(a_hit_quiet, i_clk, i_rst_n, !o_empty && !o_data.filter_passed, !o_data.promote_free && !o_data.replace_victim && o_data.key_estimate == 4'd0)

endmodule
`default_nettype wire

[bench/tb.sv]
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the frequency admission filter. Directed rows, then
// random hit/miss traffic, mostly over a small key pool, across several register
// settings. A bit-accurate predictor of sketch, doorkeeper and aging state
// gives the expected result where a row has none; every result is checked in order.
// ----------------------------------------------------------------------------
`default_nettype none
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import faf_pkg::*;

    localparam int IDLE_LIMIT = 20000;
    localparam int POOL_SIZE  = 24;

    typedef struct {
        t_in  stim;
        bit   known;
        t_out want;
    } t_row;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_push = 1'b0;
    logic                  o_full;
    t_in                   i_data = '0;
    logic                  o_empty;
    logic                  i_pop = 1'b0;
    t_out                  o_data;
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;

    frequency_admission_filter uut (.*);

    logic [15:0]        sketch_mdl [SKETCH_DEPTH];
    bit                 door_mdl [FILTER_BITS];
    logic [LIMIT_W-1:0] count_mdl;
    logic [LIMIT_W-1:0] limit_mdl;
    logic               enable_mdl;

    t_out  expected_q[$];
    int    errors = 0;
    int    idle_cycles = 0;
    bit    moved;
    logic [KEY_WIDTH-1:0] key_pool [POOL_SIZE];
    t_row  rows[$];

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    function automatic logic [63:0] rotl(logic [63:0] v, int r);
        return (v << r) | (v >> (64 - r));
    endfunction

    function automatic logic [63:0] xxh_word(logic [63:0] v, logic [63:0] seed);
        logic [63:0] h;
        logic [63:0] k;
        h = seed + PR5 + 64'd8;
        k = v * PR2;
        k = rotl(k, 31);
        k = k * PR1;
        h = h ^ k;
        h = rotl(h, 27);
        h = h * PR1 + PR4;
        h = h ^ (h >> 33);
        h = h * PR2;
        h = h ^ (h >> 29);
        h = h * PR3;
        h = h ^ (h >> 32);
        return h;
    endfunction

    function automatic logic [3:0] min_counter(logic [KEY_WIDTH-1:0] key);
        logic [3:0] m;
        logic [3:0] c;
        int         idx;
        m = COUNTER_MAX;
        for (int i = 0; i < HASH_WAYS; i++) begin
            idx = int'(xxh_word(64'(key), 64'(i)) % SKETCH_DEPTH);
            c = sketch_mdl[idx][i*4 +: 4];
            if (c < m) m = c;
        end
        return m;
    endfunction

    function automatic t_out admit_predict(t_in t);
        t_out r;
        int   idx;
        bit   all_set;
        r = '0;
        if (t.opcode) begin
            all_set = 1'b1;
            for (int i = 0; i < HASH_WAYS; i++) begin
                idx = int'(xxh_word(64'(t.block_key), 64'(i)) % FILTER_BITS);
                if (!door_mdl[idx]) all_set = 1'b0;
                door_mdl[idx] = 1'b1;
            end
            r.filter_passed = all_set;
        end
        count_mdl = count_mdl + 1'b1;
        for (int i = 0; i < HASH_WAYS; i++) begin
            idx = int'(xxh_word(64'(t.block_key), 64'(i)) % SKETCH_DEPTH);
            if (sketch_mdl[idx][i*4 +: 4] < COUNTER_MAX)
                sketch_mdl[idx][i*4 +: 4] = sketch_mdl[idx][i*4 +: 4] + 1'b1;
        end
        if (count_mdl >= limit_mdl) begin
            foreach (sketch_mdl[n]) sketch_mdl[n] = (sketch_mdl[n] >> 1) & NIB_HALF_MASK;
            foreach (door_mdl[n]) door_mdl[n] = 1'b0;
            count_mdl = '0;
            r.aged = 1'b1;
        end
        if (t.opcode && r.filter_passed) begin
            if (enable_mdl && t.free_slot) begin
                r.promote_free = 1'b1;
            end else if (t.victim_present) begin
                r.victim_estimate = min_counter(t.victim_key);
                r.key_estimate = min_counter(t.block_key);
                r.replace_victim = enable_mdl && (r.key_estimate > r.victim_estimate);
            end
        end
        return r;
    endfunction

    function automatic t_out outcome(bit p, bit pf, bit rv, logic [3:0] ke, logic [3:0] ve,
                                     bit ag);
        t_out r;
        r.filter_passed = p;
        r.promote_free = pf;
        r.replace_victim = rv;
        r.key_estimate = ke;
        r.victim_estimate = ve;
        r.aged = ag;
        return r;
    endfunction

    function automatic t_in access(bit miss, logic [KEY_WIDTH-1:0] k, logic [KEY_WIDTH-1:0] v,
                                   bit vp, bit fs);
        t_in t;
        t.opcode = miss;
        t.block_key = k;
        t.victim_key = v;
        t.victim_present = vp;
        t.free_slot = fs;
        return t;
    endfunction

    function automatic logic [KEY_WIDTH-1:0] pick_key();
        if ($urandom_range(99) < 85) return key_pool[$urandom_range(POOL_SIZE - 1)];
        return KEY_WIDTH'({$urandom, $urandom});
    endfunction

    task automatic send_access(t_in t, bit known, t_out want);
        t_out p;
        if ($urandom_range(9) < 3) begin
            i_push <= 1'b0;
            repeat ($urandom_range(9) == 0 ? 1 + $urandom_range(149) : 1 + $urandom_range(3))
                @(negedge i_clk);
        end
        i_push <= 1'b1;
        i_data <= t;
        do @(posedge i_clk); while (o_full);
        p = admit_predict(t);
        expected_q.push_back(known ? want : p);
        @(negedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        wait (expected_q.size() == 0);
        repeat (300) @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        if (idx == CFG_SAMPLE_LIMIT) limit_mdl = val;
        else if (idx == CFG_ADMISSION_ENABLE) enable_mdl = val[0];
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic random_traffic(int n);
        t_in t;
        for (int j = 0; j < n; j++) begin
            t = access($urandom_range(99) < 60, pick_key(), pick_key(), 1'($urandom_range(1)),
                       $urandom_range(99) < 30);
            send_access(t, 1'b0, '0);
        end
        i_push <= 1'b0;
    endtask

    initial begin
        forever begin
            @(negedge i_clk);
            if ($urandom_range(49) == 0) begin
                i_pop <= 1'b0;
                repeat ($urandom_range(200)) @(negedge i_clk);
            end else if ($urandom_range(9) < 3) begin
                i_pop <= 1'b0;
            end else begin
                i_pop <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        t_out want;
        moved = (i_push && !o_full) || (i_pop && !o_empty) || (i_cfg_valid && o_cfg_ready);
        if (i_rst_n && i_pop && !o_empty) begin
            if (expected_q.size() == 0) begin
                $display("%0t: unexpected result transaction %p", $realtime, o_data);
                errors++;
            end else begin
                want = expected_q.pop_front();
                if (o_data.filter_passed !== want.filter_passed)
                    $display("%0t: filter_passed exp %0d got %0d", $realtime,
                             want.filter_passed, o_data.filter_passed);
                if (o_data.promote_free !== want.promote_free)
                    $display("%0t: promote_free exp %0d got %0d", $realtime,
                             want.promote_free, o_data.promote_free);
                if (o_data.replace_victim !== want.replace_victim)
                    $display("%0t: replace_victim exp %0d got %0d", $realtime,
                             want.replace_victim, o_data.replace_victim);
                if (o_data.key_estimate !== want.key_estimate)
                    $display("%0t: key_estimate exp %0d got %0d", $realtime,
                             want.key_estimate, o_data.key_estimate);
                if (o_data.victim_estimate !== want.victim_estimate)
                    $display("%0t: victim_estimate exp %0d got %0d", $realtime,
                             want.victim_estimate, o_data.victim_estimate);
                if (o_data.aged !== want.aged)
                    $display("%0t: aged exp %0d got %0d", $realtime, want.aged, o_data.aged);
                if (o_data !== want) errors++;
            end
        end
        idle_cycles = moved ? 0 : idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("[frequency_admission_filter] ERROR");
            $finish;
        end
    end

    initial begin
        logic [KEY_WIDTH-1:0] ones;
        ones = '1;
        foreach (sketch_mdl[n]) sketch_mdl[n] = '0;
        foreach (door_mdl[n]) door_mdl[n] = 1'b0;
        count_mdl = '0;
        limit_mdl = SAMPLE_LIMIT_RST;
        enable_mdl = 1'b1;
        foreach (key_pool[n]) key_pool[n] = KEY_WIDTH'({$urandom, $urandom});
        key_pool[0] = '0;
        key_pool[1] = ones;

        rows.push_back('{access(0, '0, '0, 0, 0), 1, outcome(0, 0, 0, 0, 0, 0)});
        rows.push_back('{access(1, '0, ones, 1, 1), 1, outcome(0, 0, 0, 0, 0, 0)});
        rows.push_back('{access(1, '0, ones, 1, 1), 1, outcome(1, 1, 0, 0, 0, 0)});
        rows.push_back('{access(1, ones, '0, 1, 0), 1, outcome(0, 0, 0, 0, 0, 0)});
        rows.push_back('{access(1, ones, '0, 0, 0), 1, outcome(1, 0, 0, 0, 0, 0)});
        rows.push_back('{access(1, ones, '0, 1, 0), 0, '0});
        rows.push_back('{access(1, '0, ones, 1, 0), 0, '0});
        rows.push_back('{access(0, ones, ones, 1, 1), 1, outcome(0, 0, 0, 0, 0, 0)});
        rows.push_back('{access(0, ones, '0, 0, 1), 0, '0});
        rows.push_back('{access(1, ones, '0, 1, 1), 1, outcome(1, 1, 0, 0, 0, 0)});
        rows.push_back('{access(1, ones, 48'h0123_4567_89AB, 1, 0), 0, '0});
        rows.push_back('{access(1, 48'hAAAA_AAAA_AAAA, 48'h5555_5555_5555, 1, 0), 0, '0});
        rows.push_back('{access(1, 48'hAAAA_AAAA_AAAA, 48'h5555_5555_5555, 1, 0), 0, '0});
        rows.push_back('{access(1, 48'h5555_5555_5555, ones, 1, 0), 0, '0});

        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (rows[r]) send_access(rows[r].stim, rows[r].known, rows[r].want);
        random_traffic(300);

        write_reg(CFG_SAMPLE_LIMIT, 20'hFFFFF);
        write_reg(CFG_ADMISSION_ENABLE, 20'd0);
        random_traffic(250);
        write_reg(CFG_ADMISSION_ENABLE, 20'd1);
        write_reg(CFG_IDX_W'(3), 20'd5);
        write_reg(CFG_SAMPLE_LIMIT, 20'd40);
        random_traffic(300);
        write_reg(CFG_SAMPLE_LIMIT, 20'd7);
        random_traffic(150);
        write_reg(CFG_SAMPLE_LIMIT, 20'd1);
        write_reg(CFG_ADMISSION_ENABLE, 20'd0);
        random_traffic(40);
        write_reg(CFG_SAMPLE_LIMIT, 20'd0);
        write_reg(CFG_ADMISSION_ENABLE, 20'd1);
        random_traffic(30);
        write_reg(CFG_SAMPLE_LIMIT, SAMPLE_LIMIT_RST);
        random_traffic(300);

        wait (expected_q.size() == 0);
        repeat (300) @(posedge i_clk);
        if (errors == 0 && expected_q.size() == 0) begin
            $display("[frequency_admission_filter] OK");
        end else begin
            $display("[frequency_admission_filter] ERROR");
        end
        $finish;
    end
endmodule
`default_nettype wire
